[hw/rtl/sip_pkg.sv]
// Shared widths and types for the segment intersection point pipeline.
package sip_pkg;

    // Coordinate width, signed fixed point
    localparam int CW      = 24;
    // Coordinate difference width
    localparam int DW      = CW + 1;
    // Orientation and determinant width
    localparam int OW      = 2 * DW + 1;
    // Line constant width (a*x + b*y)
    localparam int FCW     = 2 * CW + 2;
    // Split point of a line constant for the partial products
    localparam int SPL     = FCW / 2;
    // Partial product widths: difference times upper and lower line constant half
    localparam int HPW     = DW + FCW - SPL;
    localparam int LPW     = DW + SPL + 1;
    // Full product width of a difference times a line constant
    localparam int PRW     = DW + FCW;
    // Numerator width
    localparam int NW      = PRW + 1;
    // Divider pipeline depth: one step per stage plus the sign stage
    localparam int DIV_LAT = NW + 1;

    // Result side information that travels beside the divider
    typedef struct packed {
        logic                 hit;
        logic                 degen;
        logic                 use_div;
        logic signed [CW-1:0] rx;
        logic signed [CW-1:0] ry;
    } side_t;

    // Front end output: coordinates, line terms, determinant
    typedef struct packed {
        logic                  hit_ok;
        logic signed [CW-1:0]  ax;
        logic signed [CW-1:0]  ay;
        logic signed [CW-1:0]  bx;
        logic signed [CW-1:0]  by;
        logic signed [CW-1:0]  cx;
        logic signed [CW-1:0]  cy;
        logic signed [CW-1:0]  dx;
        logic signed [CW-1:0]  dy;
        logic signed [DW-1:0]  fa;
        logic signed [DW-1:0]  fb;
        logic signed [DW-1:0]  sa;
        logic signed [DW-1:0]  sb;
        logic signed [OW-1:0]  det;
        logic signed [FCW-1:0] fc;
        logic signed [FCW-1:0] sc;
    } front_t;

    // Numerator stage output: divider operands and side information
    typedef struct packed {
        side_t           side;
        logic [NW-1:0]   num_x;
        logic [NW-1:0]   num_y;
        logic [OW-1:0]   den;
        logic            neg_x;
        logic            neg_y;
    } numer_t;

endpackage

[hw/rtl/sip_front.sv]
// Front end: differences, box test, products, orientation tests, determinant.
module sip_front
    import sip_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_vld,
    input  logic signed [CW-1:0] ax,
    input  logic signed [CW-1:0] ay,
    input  logic signed [CW-1:0] bx,
    input  logic signed [CW-1:0] by,
    input  logic signed [CW-1:0] cx,
    input  logic signed [CW-1:0] cy,
    input  logic signed [CW-1:0] dx,
    input  logic signed [CW-1:0] dy,
    output logic                 out_vld,
    output front_t               out_data
);

    typedef struct packed {
        logic                 box_ok;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [DW-1:0] fa;
        logic signed [DW-1:0] fb;
        logic signed [DW-1:0] sa;
        logic signed [DW-1:0] sb;
        logic signed [DW-1:0] e1;
        logic signed [DW-1:0] e2;
        logic signed [DW-1:0] e3;
        logic signed [DW-1:0] e4;
        logic signed [DW-1:0] h1;
        logic signed [DW-1:0] h2;
    } s1_t;

    typedef struct packed {
        logic                     box_ok;
        logic signed [CW-1:0]     ax;
        logic signed [CW-1:0]     ay;
        logic signed [CW-1:0]     bx;
        logic signed [CW-1:0]     by;
        logic signed [CW-1:0]     cx;
        logic signed [CW-1:0]     cy;
        logic signed [CW-1:0]     dx;
        logic signed [CW-1:0]     dy;
        logic signed [DW-1:0]     fa;
        logic signed [DW-1:0]     fb;
        logic signed [DW-1:0]     sa;
        logic signed [DW-1:0]     sb;
        logic signed [2*DW-1:0]   m1;
        logic signed [2*DW-1:0]   m2;
        logic signed [2*DW-1:0]   m3;
        logic signed [2*DW-1:0]   m4;
        logic signed [2*DW-1:0]   m5;
        logic signed [2*DW-1:0]   m6;
        logic signed [2*DW-1:0]   m7;
        logic signed [2*DW-1:0]   m8;
        logic signed [2*DW-1:0]   d1;
        logic signed [2*DW-1:0]   d2;
        logic signed [DW+CW-1:0]  f1;
        logic signed [DW+CW-1:0]  f2;
        logic signed [DW+CW-1:0]  c1;
        logic signed [DW+CW-1:0]  c2;
    } s2_t;

    s1_t    s1_reg, s1_next;
    s2_t    s2_reg, s2_next;
    front_t s3_reg, s3_next;
    logic   v1_reg, v2_reg, v3_reg;

    // Stage 1: differences and bounding box test
    always_comb
    begin
        logic apart;
        apart = (ax > cx && ax > dx && bx > cx && bx > dx)
             || (ax < cx && ax < dx && bx < cx && bx < dx)
             || (ay > cy && ay > dy && by > cy && by > dy)
             || (ay < cy && ay < dy && by < cy && by < dy);
        s1_next.box_ok = !apart;
        s1_next.ax = ax;
        s1_next.ay = ay;
        s1_next.bx = bx;
        s1_next.by = by;
        s1_next.cx = cx;
        s1_next.cy = cy;
        s1_next.dx = dx;
        s1_next.dy = dy;
        s1_next.fa = DW'(ay) - DW'(by);
        s1_next.fb = DW'(bx) - DW'(ax);
        s1_next.sa = DW'(cy) - DW'(dy);
        s1_next.sb = DW'(dx) - DW'(cx);
        s1_next.e1 = DW'(cx) - DW'(ax);
        s1_next.e2 = DW'(cy) - DW'(ay);
        s1_next.e3 = DW'(dx) - DW'(ax);
        s1_next.e4 = DW'(dy) - DW'(ay);
        s1_next.h1 = DW'(bx) - DW'(cx);
        s1_next.h2 = DW'(by) - DW'(cy);
    end

    // Stage 2: all products of differences and coordinates
    always_comb
    begin
        s2_next.box_ok = s1_reg.box_ok;
        s2_next.ax = s1_reg.ax;
        s2_next.ay = s1_reg.ay;
        s2_next.bx = s1_reg.bx;
        s2_next.by = s1_reg.by;
        s2_next.cx = s1_reg.cx;
        s2_next.cy = s1_reg.cy;
        s2_next.dx = s1_reg.dx;
        s2_next.dy = s1_reg.dy;
        s2_next.fa = s1_reg.fa;
        s2_next.fb = s1_reg.fb;
        s2_next.sa = s1_reg.sa;
        s2_next.sb = s1_reg.sb;
        s2_next.m1 = (2*DW)'(s1_reg.fb) * (2*DW)'(s1_reg.e2);
        s2_next.m2 = (2*DW)'(s1_reg.fa) * (2*DW)'(s1_reg.e1);
        s2_next.m3 = (2*DW)'(s1_reg.fb) * (2*DW)'(s1_reg.e4);
        s2_next.m4 = (2*DW)'(s1_reg.fa) * (2*DW)'(s1_reg.e3);
        s2_next.m5 = (2*DW)'(s1_reg.sb) * (2*DW)'(s1_reg.e2);
        s2_next.m6 = (2*DW)'(s1_reg.sa) * (2*DW)'(s1_reg.e1);
        s2_next.m7 = (2*DW)'(s1_reg.sb) * (2*DW)'(s1_reg.h2);
        s2_next.m8 = (2*DW)'(s1_reg.sa) * (2*DW)'(s1_reg.h1);
        s2_next.d1 = (2*DW)'(s1_reg.fb) * (2*DW)'(s1_reg.sa);
        s2_next.d2 = (2*DW)'(s1_reg.fa) * (2*DW)'(s1_reg.sb);
        s2_next.f1 = (DW+CW)'(s1_reg.fa) * (DW+CW)'(s1_reg.ax);
        s2_next.f2 = (DW+CW)'(s1_reg.fb) * (DW+CW)'(s1_reg.ay);
        s2_next.c1 = (DW+CW)'(s1_reg.sa) * (DW+CW)'(s1_reg.cx);
        s2_next.c2 = (DW+CW)'(s1_reg.sb) * (DW+CW)'(s1_reg.cy);
    end

    // Stage 3: orientation sums, straddle tests, determinant, line constants
    always_comb
    begin
        logic signed [OW-1:0] t1;
        logic signed [OW-1:0] t2;
        logic signed [OW-1:0] t3;
        logic signed [OW-1:0] t4;
        logic                 st1;
        logic                 st2;
        t1 = OW'(s2_reg.m1) + OW'(s2_reg.m2);
        t2 = OW'(s2_reg.m3) + OW'(s2_reg.m4);
        // t3 carries the opposite sign of the third orientation
        t3 = OW'(s2_reg.m5) + OW'(s2_reg.m6);
        t4 = OW'(s2_reg.m7) + OW'(s2_reg.m8);
        st1 = (t1 == '0) || (t2 == '0) || (t1[OW-1] != t2[OW-1]);
        st2 = (t3 == '0) || (t4 == '0) || (t3[OW-1] == t4[OW-1]);
        s3_next.hit_ok = s2_reg.box_ok && st1 && st2;
        s3_next.ax = s2_reg.ax;
        s3_next.ay = s2_reg.ay;
        s3_next.bx = s2_reg.bx;
        s3_next.by = s2_reg.by;
        s3_next.cx = s2_reg.cx;
        s3_next.cy = s2_reg.cy;
        s3_next.dx = s2_reg.dx;
        s3_next.dy = s2_reg.dy;
        s3_next.fa = s2_reg.fa;
        s3_next.fb = s2_reg.fb;
        s3_next.sa = s2_reg.sa;
        s3_next.sb = s2_reg.sb;
        s3_next.det = OW'(s2_reg.d1) - OW'(s2_reg.d2);
        s3_next.fc = FCW'(s2_reg.f1) + FCW'(s2_reg.f2);
        s3_next.sc = FCW'(s2_reg.c1) + FCW'(s2_reg.c2);
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        s3_reg <= s3_next;
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_vld  = v3_reg;
    assign out_data = s3_reg;

endmodule

[hw/rtl/sip_numer.sv]
// Special case selection and numerator build for the general solver.
module sip_numer
    import sip_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_vld,
    input  front_t in_data,
    output logic   out_vld,
    output numer_t out_data
);

    typedef struct packed {
        side_t                side;
        logic signed [OW-1:0] det;
        logic signed [HPW-1:0] bs_h;
        logic signed [LPW-1:0] bs_l;
        logic signed [HPW-1:0] sf_h;
        logic signed [LPW-1:0] sf_l;
        logic signed [HPW-1:0] as_h;
        logic signed [LPW-1:0] as_l;
        logic signed [HPW-1:0] af_h;
        logic signed [LPW-1:0] af_l;
    } s4_t;

    typedef struct packed {
        side_t                 side;
        logic signed [OW-1:0]  det;
        logic signed [PRW-1:0] bs;
        logic signed [PRW-1:0] sf;
        logic signed [PRW-1:0] as_p;
        logic signed [PRW-1:0] af;
    } s5_t;

    typedef struct packed {
        side_t                side;
        logic signed [OW-1:0] det;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
    } s6_t;

    s4_t    s4_reg, s4_next;
    s5_t    s5_reg, s5_next;
    s6_t    s6_reg, s6_next;
    numer_t s7_reg, s7_next;
    logic   v4_reg, v5_reg, v6_reg, v7_reg;

    // Stage 4: pick the special case, start the split products
    always_comb
    begin
        logic                  first_vert;
        logic                  first_horz;
        logic                  second_vert;
        logic                  second_horz;
        logic                  c_in_y;
        logic                  d_in_y;
        logic                  c_in_x;
        logic                  d_in_x;
        logic                  general;
        logic signed [FCW-SPL-1:0] sc_hi;
        logic signed [FCW-SPL-1:0] fc_hi;
        logic signed [SPL:0]       sc_lo;
        logic signed [SPL:0]       fc_lo;
        first_vert  = in_data.ax == in_data.bx;
        first_horz  = in_data.ay == in_data.by;
        second_vert = in_data.cx == in_data.dx;
        second_horz = in_data.cy == in_data.dy;
        c_in_y = (in_data.ay <= in_data.cy || in_data.by <= in_data.cy)
              && (in_data.ay >= in_data.cy || in_data.by >= in_data.cy);
        d_in_y = (in_data.ay <= in_data.dy || in_data.by <= in_data.dy)
              && (in_data.ay >= in_data.dy || in_data.by >= in_data.dy);
        c_in_x = (in_data.ax <= in_data.cx || in_data.bx <= in_data.cx)
              && (in_data.ax >= in_data.cx || in_data.bx >= in_data.cx);
        d_in_x = (in_data.ax <= in_data.dx || in_data.bx <= in_data.dx)
              && (in_data.ax >= in_data.dx || in_data.bx >= in_data.dx);
        general = 1'b0;
        s4_next.side.rx = '0;
        s4_next.side.ry = '0;
        if (first_vert && second_vert)
        begin
            if (c_in_y)
            begin
                s4_next.side.rx = in_data.cx;
                s4_next.side.ry = in_data.cy;
            end
            else if (d_in_y)
            begin
                s4_next.side.rx = in_data.dx;
                s4_next.side.ry = in_data.dy;
            end
            else
            begin
                s4_next.side.rx = in_data.ax;
                s4_next.side.ry = in_data.ay;
            end
        end
        else if (first_horz && second_horz)
        begin
            if (c_in_x)
            begin
                s4_next.side.rx = in_data.cx;
                s4_next.side.ry = in_data.cy;
            end
            else if (d_in_x)
            begin
                s4_next.side.rx = in_data.dx;
                s4_next.side.ry = in_data.dy;
            end
            else
            begin
                s4_next.side.rx = in_data.ax;
                s4_next.side.ry = in_data.ay;
            end
        end
        else if (first_vert && second_horz)
        begin
            s4_next.side.rx = in_data.ax;
            s4_next.side.ry = in_data.cy;
        end
        else if (second_vert && first_horz)
        begin
            s4_next.side.rx = in_data.cx;
            s4_next.side.ry = in_data.ay;
        end
        else if ((in_data.ax == in_data.cx && in_data.ay == in_data.cy)
              || (in_data.ax == in_data.dx && in_data.ay == in_data.dy))
        begin
            s4_next.side.rx = in_data.ax;
            s4_next.side.ry = in_data.ay;
        end
        else if ((in_data.bx == in_data.dx && in_data.by == in_data.dy)
              || (in_data.bx == in_data.cx && in_data.by == in_data.cy))
        begin
            s4_next.side.rx = in_data.bx;
            s4_next.side.ry = in_data.by;
        end
        else
        begin
            // general solver; a zero determinant falls back to the first start
            general = 1'b1;
            s4_next.side.rx = in_data.ax;
            s4_next.side.ry = in_data.ay;
        end
        s4_next.side.hit     = in_data.hit_ok;
        s4_next.side.degen   = in_data.hit_ok && general && (in_data.det == '0);
        s4_next.side.use_div = in_data.hit_ok && general && (in_data.det != '0);
        if (!in_data.hit_ok)
        begin
            s4_next.side.rx = '0;
            s4_next.side.ry = '0;
        end
        s4_next.det = in_data.det;
        sc_hi = in_data.sc[FCW-1:SPL];
        fc_hi = in_data.fc[FCW-1:SPL];
        sc_lo = $signed({1'b0, in_data.sc[SPL-1:0]});
        fc_lo = $signed({1'b0, in_data.fc[SPL-1:0]});
        s4_next.bs_h = HPW'(in_data.fb) * HPW'(sc_hi);
        s4_next.bs_l = LPW'(in_data.fb) * LPW'(sc_lo);
        s4_next.sf_h = HPW'(in_data.sb) * HPW'(fc_hi);
        s4_next.sf_l = LPW'(in_data.sb) * LPW'(fc_lo);
        s4_next.as_h = HPW'(in_data.fa) * HPW'(sc_hi);
        s4_next.as_l = LPW'(in_data.fa) * LPW'(sc_lo);
        s4_next.af_h = HPW'(in_data.sa) * HPW'(fc_hi);
        s4_next.af_l = LPW'(in_data.sa) * LPW'(fc_lo);
    end

    // Stage 5: join the partial products
    always_comb
    begin
        s5_next.side = s4_reg.side;
        s5_next.det  = s4_reg.det;
        s5_next.bs   = (PRW'(s4_reg.bs_h) <<< SPL) + PRW'(s4_reg.bs_l);
        s5_next.sf   = (PRW'(s4_reg.sf_h) <<< SPL) + PRW'(s4_reg.sf_l);
        s5_next.as_p = (PRW'(s4_reg.as_h) <<< SPL) + PRW'(s4_reg.as_l);
        s5_next.af   = (PRW'(s4_reg.af_h) <<< SPL) + PRW'(s4_reg.af_l);
    end

    // Stage 6: numerators
    always_comb
    begin
        s6_next.side = s5_reg.side;
        s6_next.det  = s5_reg.det;
        s6_next.nx   = NW'(s5_reg.bs) - NW'(s5_reg.sf);
        s6_next.ny   = NW'(s5_reg.as_p) - NW'(s5_reg.af);
    end

    // Stage 7: magnitudes and quotient signs
    always_comb
    begin
        logic det_neg;
        det_neg = s6_reg.det[OW-1];
        s7_next.side  = s6_reg.side;
        s7_next.num_x = s6_reg.nx[NW-1] ? NW'(-s6_reg.nx) : NW'(s6_reg.nx);
        s7_next.num_y = s6_reg.ny[NW-1] ? NW'(-s6_reg.ny) : NW'(s6_reg.ny);
        s7_next.den   = det_neg ? OW'(-s6_reg.det) : OW'(s6_reg.det);
        s7_next.neg_x = s6_reg.nx[NW-1] ^ det_neg;
        s7_next.neg_y = s6_reg.ny[NW-1] ^ ~det_neg;
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        s4_reg <= s4_next;
        s5_reg <= s5_next;
        s6_reg <= s6_next;
        s7_reg <= s7_next;
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= in_vld;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    assign out_vld  = v7_reg;
    assign out_data = s7_reg;

endmodule

[hw/rtl/sip_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, signed low result.
module sip_divider
    import sip_pkg::*;
(
    input  logic                 clk,
    input  logic [NW-1:0]        num,
    input  logic [OW-1:0]        den,
    input  logic                 neg,
    output logic signed [CW-1:0] quot
);

    logic [OW-1:0] rem_reg [NW];
    logic [OW-1:0] rem_next [NW];
    logic [NW-1:0] acc_reg [NW];
    logic [NW-1:0] acc_next [NW];
    logic [OW-1:0] den_reg [NW];
    logic [OW-1:0] den_next [NW];
    logic          neg_reg [NW];
    logic          neg_next [NW];
    logic [CW-1:0] quot_reg;

    // One shift and trial subtract per stage
    always_comb
    begin
        logic [OW-1:0] prem;
        logic [NW-1:0] pacc;
        logic [OW-1:0] pden;
        logic          pneg;
        logic [OW:0]   trial;
        logic          ge;
        for (int i = 0; i < NW; i++)
        begin
            if (i == 0)
            begin
                prem = '0;
                pacc = num;
                pden = den;
                pneg = neg;
            end
            else
            begin
                prem = rem_reg[i-1];
                pacc = acc_reg[i-1];
                pden = den_reg[i-1];
                pneg = neg_reg[i-1];
            end
            trial = {prem, pacc[NW-1]};
            ge = trial >= {1'b0, pden};
            rem_next[i] = ge ? OW'(trial - {1'b0, pden}) : trial[OW-1:0];
            acc_next[i] = {pacc[NW-2:0], ge};
            den_next[i] = pden;
            neg_next[i] = pneg;
        end
    end

    // Advance the stages and apply the sign
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NW; i++)
        begin
            rem_reg[i] <= rem_next[i];
            acc_reg[i] <= acc_next[i];
            den_reg[i] <= den_next[i];
            neg_reg[i] <= neg_next[i];
        end
        quot_reg <= neg_reg[NW-1] ? CW'(-acc_reg[NW-1][CW-1:0])
                                  : acc_reg[NW-1][CW-1:0];
    end

    assign quot = $signed(quot_reg);

endmodule

[hw/rtl/segment_intersection_point.sv]
// Top level of the segment intersection point pipeline.
//
//  channel   direction  handshake           payload
//  request   in         start / busy        first_*, second_* coordinates
//  result    out        done (one cycle)    hit, cross_x, cross_y, degenerate
//
// A request is taken in every cycle; busy is always low.
// A request passes three front end stages, four numerator stages, and
// one divider stage per numerator bit plus a sign stage.
// Reset clears the valid bits only; payload registers hold no reset.
// Results leave on done for one cycle and cannot be held off.
module segment_intersection_point
    import sip_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [CW-1:0] first_start_x,
    input  logic signed [CW-1:0] first_start_y,
    input  logic signed [CW-1:0] first_end_x,
    input  logic signed [CW-1:0] first_end_y,
    input  logic signed [CW-1:0] second_start_x,
    input  logic signed [CW-1:0] second_start_y,
    input  logic signed [CW-1:0] second_end_x,
    input  logic signed [CW-1:0] second_end_y,
    output logic                 done,
    output logic                 hit,
    output logic signed [CW-1:0] cross_x,
    output logic signed [CW-1:0] cross_y,
    output logic                 degenerate
);

    logic                 front_vld;
    front_t               front_data;
    logic                 numer_vld;
    numer_t               numer_data;
    logic signed [CW-1:0] quot_x;
    logic signed [CW-1:0] quot_y;
    side_t                side_reg [DIV_LAT];
    logic [DIV_LAT-1:0]   vld_reg;

    assign busy = 1'b0;

    sip_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (start),
        .ax       (first_start_x),
        .ay       (first_start_y),
        .bx       (first_end_x),
        .by       (first_end_y),
        .cx       (second_start_x),
        .cy       (second_start_y),
        .dx       (second_end_x),
        .dy       (second_end_y),
        .out_vld  (front_vld),
        .out_data (front_data)
    );

    sip_numer u_numer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (front_vld),
        .in_data  (front_data),
        .out_vld  (numer_vld),
        .out_data (numer_data)
    );

    sip_divider u_div_x (
        .clk  (clk),
        .num  (numer_data.num_x),
        .den  (numer_data.den),
        .neg  (numer_data.neg_x),
        .quot (quot_x)
    );

    sip_divider u_div_y (
        .clk  (clk),
        .num  (numer_data.num_y),
        .den  (numer_data.den),
        .neg  (numer_data.neg_y),
        .quot (quot_y)
    );

    // Hold the side information beside the dividers
    always_ff @(posedge clk)
    begin
        side_reg[0] <= numer_data.side;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // Advance the valid bits beside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DIV_LAT-2:0], numer_vld};
        end
    end

    // Drive the result
    assign done       = vld_reg[DIV_LAT-1];
    assign hit        = side_reg[DIV_LAT-1].hit;
    assign degenerate = side_reg[DIV_LAT-1].degen;
    assign cross_x    = side_reg[DIV_LAT-1].use_div ? quot_x : side_reg[DIV_LAT-1].rx;
    assign cross_y    = side_reg[DIV_LAT-1].use_div ? quot_y : side_reg[DIV_LAT-1].ry;

endmodule

[verif/segment_intersection_point_tb.sv]
// Self-checking testbench for the segment intersection point pipeline.
module segment_intersection_point_tb;
    import sip_pkg::*;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        logic   hit;
        coord_t x;
        coord_t y;
        logic   degen;
    } crossing_t;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    coord_t first_start_x, first_start_y, first_end_x, first_end_y;
    coord_t second_start_x, second_start_y, second_end_x, second_end_y;
    logic   done;
    logic   hit;
    coord_t cross_x, cross_y;
    logic   degenerate;

    crossing_t expected_crossings[$];
    int        mismatch_count;
    int        cycle_count;
    bit        gaps_enabled;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 120;

    segment_intersection_point dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .first_start_x(first_start_x), .first_start_y(first_start_y),
        .first_end_x(first_end_x), .first_end_y(first_end_y),
        .second_start_x(second_start_x), .second_start_y(second_start_y),
        .second_end_x(second_end_x), .second_end_y(second_end_y),
        .done(done), .hit(hit), .cross_x(cross_x), .cross_y(cross_y),
        .degenerate(degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Sign of (e - b) x (p - b), exact
    function automatic int orient_sign(longint bx, longint by, longint ex, longint ey,
                                       longint px, longint py);
        longint l;
        longint r;
        l = (ex - bx) * (py - by);
        r = (ey - by) * (px - bx);
        return (l > r) ? 1 : ((l < r) ? -1 : 0);
    endfunction

    function automatic bit straddle(int a, int b);
        return a == 0 || b == 0 || a != b;
    endfunction

    // Work out the crossing of two segments
    function automatic crossing_t predict_crossing(coord_t iax, coord_t iay, coord_t ibx,
                                                   coord_t iby, coord_t icx, coord_t icy,
                                                   coord_t idx, coord_t idy);
        crossing_t res;
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint fminx, fmaxx, fminy, fmaxy, sminx, smaxx, sminy, smaxy;
        logic signed [127:0] fa, fb, fc, sa, sb, sc, det, nx, ny;
        ax = longint'(iax); ay = longint'(iay); bx = longint'(ibx); by = longint'(iby);
        cx = longint'(icx); cy = longint'(icy); dx = longint'(idx); dy = longint'(idy);
        fminx = ax < bx ? ax : bx; fmaxx = ax > bx ? ax : bx;
        fminy = ay < by ? ay : by; fmaxy = ay > by ? ay : by;
        sminx = cx < dx ? cx : dx; smaxx = cx > dx ? cx : dx;
        sminy = cy < dy ? cy : dy; smaxy = cy > dy ? cy : dy;
        res = '{1'b0, '0, '0, 1'b0};
        if (!(fminx > smaxx || fmaxx < sminx || fminy > smaxy || fmaxy < sminy)
            && straddle(orient_sign(ax, ay, bx, by, cx, cy),
                        orient_sign(ax, ay, bx, by, dx, dy))
            && straddle(orient_sign(cx, cy, dx, dy, ax, ay),
                        orient_sign(cx, cy, dx, dy, bx, by)))
        begin
            res.hit = 1'b1;
            if (ax == bx && cx == dx)
            begin
                if (fminy <= cy && cy <= fmaxy) begin res.x = icx; res.y = icy; end
                else if (fminy <= dy && dy <= fmaxy) begin res.x = idx; res.y = idy; end
                else begin res.x = iax; res.y = iay; end
            end
            else if (ay == by && cy == dy)
            begin
                if (fminx <= cx && cx <= fmaxx) begin res.x = icx; res.y = icy; end
                else if (fminx <= dx && dx <= fmaxx) begin res.x = idx; res.y = idy; end
                else begin res.x = iax; res.y = iay; end
            end
            else if (ax == bx && cy == dy)
            begin
                res.x = iax; res.y = icy;
            end
            else if (cx == dx && ay == by)
            begin
                res.x = icx; res.y = iay;
            end
            else if ((ax == cx && ay == cy) || (ax == dx && ay == dy))
            begin
                res.x = iax; res.y = iay;
            end
            else if ((bx == dx && by == dy) || (bx == cx && by == cy))
            begin
                res.x = ibx; res.y = iby;
            end
            else
            begin
                fa = 128'(ay - by); fb = 128'(bx - ax);
                fc = fa * 128'(ax) + fb * 128'(ay);
                sa = 128'(cy - dy); sb = 128'(dx - cx);
                sc = sa * 128'(cx) + sb * 128'(cy);
                det = fb * sa - fa * sb;
                if (det == 0)
                begin
                    res.degen = 1'b1;
                    res.x = iax; res.y = iay;
                end
                else
                begin
                    nx = fb * sc - sb * fc;
                    ny = fa * sc - sa * fc;
                    nx = nx / det;
                    ny = ny / (-det);
                    res.x = nx[CW-1:0];
                    res.y = ny[CW-1:0];
                end
            end
        end
        return res;
    endfunction

    // Drive one request and hold until it is taken
    task automatic send_request(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                coord_t cx, coord_t cy, coord_t dx, coord_t dy);
        int gap;
        if (gaps_enabled && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        first_start_x <= ax; first_start_y <= ay;
        first_end_x <= bx; first_end_y <= by;
        second_start_x <= cx; second_start_y <= cy;
        second_end_x <= dx; second_end_y <= dy;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_crossings.push_back(predict_crossing(ax, ay, bx, by, cx, cy, dx, dy));
    endtask

    task automatic idle_start();
        start <= 1'b0;
    endtask

    // Hold until every outstanding result has come
    task automatic wait_results();
        idle_start();
        while (expected_crossings.size() != 0) @(posedge clk);
    endtask

    // Random coordinate: small, medium, fully random or extreme, with equal weight
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 3))
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(0, 64)) - 32);
            2: return $urandom_range(0, 1) ? coord_t'(24'h7fffff) : coord_t'(24'h800000);
            default: return coord_t'($signed($urandom_range(0, 4096)) - 2048);
        endcase
    endfunction

    task automatic test_directed();
        coord_t mx, mn;
        mx = 24'h7fffff; mn = 24'h800000;
        // plain crossing, miss, extremes
        send_request(0, 0, 256, 256, 0, 256, 256, 0);
        send_request(0, 0, 10, 10, 100, 100, 200, 300);
        send_request(mn, mn, mx, mx, mn, mx, mx, mn);
        send_request(mx, mn, mn, mx, mn, mn, mx, mx);
        // both vertical: second start, second end, first start
        send_request(5, 0, 5, 100, 5, 50, 5, 200);
        send_request(5, 0, 5, 100, 5, -50, 5, 60);
        send_request(5, 10, 5, 20, 5, 0, 5, 30);
        // both horizontal
        send_request(0, 7, 100, 7, 50, 7, 200, 7);
        send_request(0, 7, 100, 7, -50, 7, 60, 7);
        send_request(10, 7, 20, 7, 0, 7, 30, 7);
        // perpendicular axis pairs
        send_request(3, -10, 3, 10, -10, 4, 10, 4);
        send_request(-10, 4, 10, 4, 3, -10, 3, 10);
        // shared endpoints
        send_request(1, 1, 9, 3, 1, 1, -5, 7);
        send_request(1, 1, 9, 3, -5, 7, 1, 1);
        send_request(9, 3, 1, 1, -5, 7, 1, 1);
        send_request(9, 3, 1, 1, 1, 1, -5, 7);
        // collinear overlap and a point-sized first segment
        send_request(0, 0, 10, 10, 5, 5, 20, 20);
        send_request(4, 4, 4, 4, 0, 0, 8, 8);
        // touching at a mid point, truncated quotient, coincident points
        send_request(0, 0, 10, 0, 5, 0, 7, 9);
        send_request(0, 0, 7, 3, 1, 2, 6, -1);
        send_request(mn, mx, mn, mx, mn, mx, mn, mx);
        wait_results();
    endtask

    task automatic test_random_pairs(int count, bit gaps);
        coord_t ax, ay, bx, by, cx, cy, dx, dy;
        gaps_enabled = gaps;
        for (int i = 0; i < count; i++)
        begin
            ax = rand_coord(); ay = rand_coord(); bx = rand_coord(); by = rand_coord();
            cx = rand_coord(); cy = rand_coord(); dx = rand_coord(); dy = rand_coord();
            // bias towards special shapes and crossings
            case ($urandom_range(0, 9))
                0: begin bx = ax; dx = cx; end
                1: begin by = ay; dy = cy; end
                2: begin bx = ax; dy = cy; end
                3: begin dx = cx; by = ay; end
                4: begin cx = ax; cy = ay; end
                5: begin dx = bx; dy = by; end
                6: begin cx = ax + (bx - ax) / 2; cy = ay + (by - ay) / 2;
                         dx = bx; dy = by; end
                7: begin cx = -ax; cy = ay; dx = ax; dy = -ay; bx = -ax; by = -ay; end
                default: ;
            endcase
            send_request(ax, ay, bx, by, cx, cy, dx, dy);
        end
        gaps_enabled = 1'b0;
    endtask

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        crossing_t want;
        if (rst_n && done)
        begin
            if (expected_crossings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result hit=%0b x=%0d y=%0d", hit, cross_x, cross_y);
            end
            else
            begin
                want = expected_crossings.pop_front();
                if (want.hit !== hit || want.x !== cross_x || want.y !== cross_y
                    || want.degen !== degenerate)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %0b %0d %0d %0b got %0b %0d %0d %0b",
                                 want.hit, want.x, want.y, want.degen,
                                 hit, cross_x, cross_y, degenerate);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        gaps_enabled = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        first_start_x = '0; first_start_y = '0; first_end_x = '0; first_end_y = '0;
        second_start_x = '0; second_start_y = '0; second_end_x = '0; second_end_y = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_pairs(1200, 1'b1);
        wait_results();
        test_random_pairs(500, 1'b0);
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_crossings.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
